// ===== rtl/swdh_pkg.sv =====
// Package for the SWD host transaction engine: beat types, codes and the
// header and result helper functions. No dependencies.

package swdh_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned AddrWidth = 8;
   localparam int unsigned AckWidth  = 3;
   localparam int unsigned CntWidth  = 8;

   // result kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // ack codes
   localparam logic [AckWidth-1:0] ACK_OK    = 3'd1;
   localparam logic [AckWidth-1:0] ACK_WAIT  = 3'd2;
   localparam logic [AckWidth-1:0] ACK_FAULT = 3'd4;

   localparam logic [AddrWidth-1:0] RDBUFF_ADDR = 8'h0C;
   localparam logic [CntWidth-1:0]  RETRY_RESET = 8'd100;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic                 access_port;
      logic                 read_access;
      logic [AddrWidth-1:0] reg_address;
      logic [WordWidth-1:0] write_value;
      logic [AckWidth-1:0]  reply_ack;
      logic [WordWidth-1:0] reply_data;
      logic                 reply_parity;
   } item_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           request_byte;
      logic [WordWidth-1:0] write_word;
      logic                 write_parity;
      logic                 status;
      logic [WordWidth-1:0] read_value;
      logic                 last_of_run;
   } result_type;

   // one or two result beats produced by one item
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } pair_type;

   // sequencer to stages
   typedef struct packed {
      logic advance;  // input item consumed this cycle
      logic load;     // result pair written to the output stage
   } seq_ctl_type;

   // request header: start, APnDP, RnW, A[3:2], parity, stop, park
   function automatic logic [7:0] build_header(input logic ap, input logic rd,
                                               input logic [AddrWidth-1:0] addr);
      logic [7:0] h;
      h      = {1'b1, 1'b0, 1'b0, addr[3:2], rd, ap, 1'b1};
      h[5]   = ^h[4:1];
      return h;
   endfunction

   function automatic result_type mk_request(input logic [7:0] hdr);
      result_type r;
      r              = '0;
      r.kind         = KIND_REQUEST;
      r.request_byte = hdr;
      r.last_of_run  = 1'b1;
      return r;
   endfunction

   function automatic result_type mk_write(input logic [WordWidth-1:0] word);
      result_type r;
      r              = '0;
      r.kind         = KIND_WRITE;
      r.write_word   = word;
      r.write_parity = ^word;
      return r;
   endfunction

   function automatic result_type mk_done(input logic st, input logic [WordWidth-1:0] rval);
      result_type r;
      r             = '0;
      r.kind        = KIND_DONE;
      r.status      = st;
      r.read_value  = rval;
      r.last_of_run = 1'b1;
      return r;
   endfunction

endpackage

// ===== rtl/swdh_if.sv =====
// Channel interfaces of the SWD host transaction engine: command/reply,
// result and register write. Depends on swdh_pkg.

interface swdh_req_if;
   import swdh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic                 access_port;
   logic                 read_access;
   logic [AddrWidth-1:0] reg_address;
   logic [WordWidth-1:0] write_value;
   logic [AckWidth-1:0]  reply_ack;
   logic [WordWidth-1:0] reply_data;
   logic                 reply_parity;

   modport source (output valid, operation, access_port, read_access, reg_address,
                   write_value, reply_ack, reply_data, reply_parity, input ready);
   modport sink   (input valid, operation, access_port, read_access, reg_address,
                   write_value, reply_ack, reply_data, reply_parity, output ready);
endinterface

interface swdh_rsp_if;
   import swdh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           result_kind;
   logic [7:0]           request_byte;
   logic [WordWidth-1:0] write_word;
   logic                 write_parity;
   logic                 status;
   logic [WordWidth-1:0] read_value;
   logic                 last_of_run;

   modport source (output valid, result_kind, request_byte, write_word, write_parity,
                   status, read_value, last_of_run, input ready);
   modport sink   (input valid, result_kind, request_byte, write_word, write_parity,
                   status, read_value, last_of_run, output ready);
endinterface

interface swdh_csr_if;
   import swdh_pkg::*;
   logic                valid;
   logic                ready;
   logic [CntWidth-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/swdh_in_stage.sv =====
// Input register of the SWD host transaction engine: holds one accepted beat
// until the sequencer consumes it. Depends on swdh_pkg and swdh_req_if.

module swdh_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   swdh_req_if.sink              req,
   input  swdh_pkg::seq_ctl_type ctl,
   output logic                  item_valid,
   output swdh_pkg::item_type    item
);
   import swdh_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req.ready = !valid_ff || ctl.advance;
   assign take      = req.valid && req.ready;
   assign valid_in  = take ? 1'b1 : (ctl.advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{operation:    req.operation,
                      access_port:  req.access_port,
                      read_access:  req.read_access,
                      reg_address:  req.reg_address,
                      write_value:  req.write_value,
                      reply_ack:    req.reply_ack,
                      reply_data:   req.reply_data,
                      reply_parity: req.reply_parity};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/swdh_seq.sv =====
// Transaction sequencer: phase, retry count, pending header and write word,
// and the retry limit register. Depends on swdh_pkg and swdh_csr_if.

module swdh_seq (
   input  logic                  clock,
   input  logic                  reset,
   swdh_csr_if.sink              csr,
   input  logic                  item_valid,
   input  swdh_pkg::item_type    item,
   input  logic                  pair_free,
   output swdh_pkg::seq_ctl_type ctl,
   output swdh_pkg::pair_type    pair
);
   import swdh_pkg::*;

   localparam logic PHASE_IDLE = 1'b0;
   localparam logic PHASE_BUSY = 1'b1;

   logic                 phase_ff, phase_in;
   logic [CntWidth-1:0]  attempt_ff, attempt_in;
   logic [7:0]           pend_req_ff, pend_req_in;
   logic [WordWidth-1:0] pend_wr_ff, pend_wr_in;
   logic                 posted_ff, posted_in;
   logic [CntWidth-1:0]  limit_ff;
   logic                 produces;
   pair_type             pair_c;

   assign csr.ready = 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      attempt_in  = attempt_ff;
      pend_req_in = pend_req_ff;
      pend_wr_in  = pend_wr_ff;
      posted_in   = posted_ff;
      produces    = 1'b0;
      pair_c      = '0;
      if (!item.operation) begin
         if (phase_ff == PHASE_IDLE) begin
            pend_req_in  = build_header(item.access_port, item.read_access, item.reg_address);
            pend_wr_in   = item.write_value;
            posted_in    = item.access_port & item.read_access;
            attempt_in   = 8'd1;
            phase_in     = PHASE_BUSY;
            produces     = 1'b1;
            pair_c.first = mk_request(pend_req_in);
         end
      end else if (phase_ff == PHASE_BUSY) begin
         produces = 1'b1;
         if (item.reply_ack == ACK_WAIT) begin
            if (attempt_ff < limit_ff) begin
               attempt_in   = attempt_ff + 8'd1;
               pair_c.first = mk_request(pend_req_ff);
            end else begin
               phase_in     = PHASE_IDLE;
               posted_in    = 1'b0;
               pair_c.first = mk_done(STATUS_FAIL, '0);
            end
         end else if (item.reply_ack != ACK_OK) begin
            // fault and the undefined ack codes
            phase_in     = PHASE_IDLE;
            posted_in    = 1'b0;
            pair_c.first = mk_done(STATUS_FAIL, '0);
         end else if (!pend_req_ff[2]) begin
            phase_in      = PHASE_IDLE;
            posted_in     = 1'b0;
            pair_c.two    = 1'b1;
            pair_c.first  = mk_write(pend_wr_ff);
            pair_c.second = mk_done(STATUS_OK, '0);
         end else if ((^item.reply_data) != item.reply_parity) begin
            phase_in     = PHASE_IDLE;
            posted_in    = 1'b0;
            pair_c.first = mk_done(STATUS_FAIL, '0);
         end else if (posted_ff) begin
            // AP read data arrives on the following RDBUFF read
            posted_in    = 1'b0;
            pend_req_in  = build_header(1'b0, 1'b1, RDBUFF_ADDR);
            attempt_in   = 8'd1;
            pair_c.first = mk_request(pend_req_in);
         end else begin
            phase_in     = PHASE_IDLE;
            posted_in    = 1'b0;
            pair_c.first = mk_done(STATUS_OK, item.reply_data);
         end
      end
   end

   assign ctl.advance = item_valid && (!produces || pair_free);
   assign ctl.load    = ctl.advance && produces;
   assign pair        = pair_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         attempt_ff  <= '0;
         pend_req_ff <= '0;
         pend_wr_ff  <= '0;
         posted_ff   <= 1'b0;
      end else if (ctl.advance) begin
         phase_ff    <= phase_in;
         attempt_ff  <= attempt_in;
         pend_req_ff <= pend_req_in;
         pend_wr_ff  <= pend_wr_in;
         posted_ff   <= posted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_RESET;
      end else if (csr.valid) begin
         limit_ff <= csr.data;
      end
   end

endmodule

// ===== rtl/swdh_out_stage.sv =====
// Result register: holds one or two result beats and hands them out in
// order. Depends on swdh_pkg and swdh_rsp_if.

module swdh_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  swdh_pkg::seq_ctl_type ctl,
   input  swdh_pkg::pair_type    pair,
   output logic                  pair_free,
   swdh_rsp_if.source            rsp
);
   import swdh_pkg::*;

   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   pair_type   pair_ff;
   result_type beat;
   logic       last_beat, fire;

   assign beat      = sel_ff ? pair_ff.second : pair_ff.first;
   assign last_beat = !pair_ff.two || sel_ff;
   assign fire      = valid_ff && rsp.ready;
   assign pair_free = !valid_ff || (rsp.ready && last_beat);

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (fire) begin
         if (last_beat) begin
            valid_in = 1'b0;
            sel_in   = 1'b0;
         end else begin
            sel_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pair_ff <= pair;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.result_kind  = beat.kind;
   assign rsp.request_byte = beat.request_byte;
   assign rsp.write_word   = beat.write_word;
   assign rsp.write_parity = beat.write_parity;
   assign rsp.status       = beat.status;
   assign rsp.read_value   = beat.read_value;
   assign rsp.last_of_run  = beat.last_of_run;

endmodule

// ===== rtl/swd_host_transaction_engine_core.sv =====
// SWD host transaction engine, top level. A beat taken on req passes the
// input register, then the result register, before its first result shows
// on rsp. Throughput: one req beat per cycle while rsp takes every beat;
// only an OK write reply needs two rsp beats, which can hold req back.
// Reset (synchronous, active high) empties both registers, returns to idle
// and loads the retry limit with 100. Depends on swdh_pkg, swdh_if.

module swd_host_transaction_engine_core (
   input  logic       clock,
   input  logic       reset,
   swdh_req_if.sink   req,
   swdh_rsp_if.source rsp,
   swdh_csr_if.sink   csr
);
   import swdh_pkg::*;

   // input register -> sequencer
   logic        item_valid;
   item_type    item;
   // sequencer -> stages
   seq_ctl_type ctl;
   pair_type    pair;
   // result register back-pressure
   logic        pair_free;

   // Input register. req.ready is high whenever the held item will be
   // consumed this cycle, so commands stream in at full rate.
   swdh_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .ctl        (ctl),
      .item_valid (item_valid),
      .item       (item)
   );

   // Sequencer: builds the header, counts WAIT retries against the limit,
   // chains the RDBUFF read after a posted AP read. Items that produce no
   // result (command while busy, reply while idle) drain without waiting
   // on the result register.
   swdh_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .pair_free  (pair_free),
      .ctl        (ctl),
      .pair       (pair)
   );

   // Result register: one or two beats per item, handed out in order.
   swdh_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .pair      (pair),
      .pair_free (pair_free),
      .rsp       (rsp)
   );

   // The result register is only loaded when it has room.
   a_load_has_room: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> pair_free)
      else $error("result pair loaded over a pending beat");

   // A held item that is not consumed must still be there next cycle.
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      item_valid && !ctl.advance |=> item_valid)
      else $error("input item dropped");

   // A write word beat is always followed by a successful completion.
   a_write_then_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.result_kind == KIND_WRITE |=>
         rsp.valid && rsp.result_kind == KIND_DONE && rsp.status == STATUS_OK)
      else $error("write word not followed by completion");

   // Completions close the run of an item.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == KIND_DONE |-> rsp.last_of_run)
      else $error("completion without last_of_run");

endmodule
